// File: sv/seeded_bloom_filter_defines.svh
// ----------------------------------------------------------------------------
// Seeded Bloom filter assertion macros
// Concurrent assertion wrappers clocked on clk; SBF_ASSERT is disabled while rst_n is low, SBF_ASSERT_ALWAYS is not.
// ----------------------------------------------------------------------------
`ifndef SEEDED_BLOOM_FILTER_DEFINES_SVH
`define SEEDED_BLOOM_FILTER_DEFINES_SVH
`ifndef ASSERT_OFF
`define SBF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SBF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SBF_ASSERT(label, prop, msg)
`define SBF_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// File: sv/sbf_pkg.sv
// ----------------------------------------------------------------------------
// Seeded Bloom filter package
// Sizes, operation codes, controller states, the divider interface types and the rotate function.
// ----------------------------------------------------------------------------
package sbf_pkg;
  localparam int MAX_HASHES = 16;
  localparam int MAX_BYTES  = 8192;
  localparam int ROTATE_BY  = 17;
  localparam int ADDR_W     = $clog2(MAX_BYTES);
  localparam int SEED_W     = $clog2(MAX_HASHES);
  localparam int BYTES_W    = 14;
  localparam int HCNT_W     = 5;
  localparam int COUNT_W    = 20;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_SEED   = 2'd3
  } sbf_op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_DIV,
    ST_RD,
    ST_CHK,
    ST_DONE
  } sbf_state_t;

  typedef struct packed {
    logic               start;
    logic [63:0]        dividend;
    logic [BYTES_W-1:0] divisor;
  } sbf_div_req_t;

  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] rem;
  } sbf_div_rsp_t;

  function automatic logic [63:0] rotl(input logic [63:0] v);
    return (v << ROTATE_BY) | (v >> (64 - ROTATE_BY));
  endfunction
endpackage

// File: sv/sbf_mod.sv
// ----------------------------------------------------------------------------
// Seeded Bloom filter modulo unit
// Restoring remainder of a 64-bit word by a byte count, four bits per cycle.
// ----------------------------------------------------------------------------
module sbf_mod import sbf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  sbf_div_req_t req,
  output sbf_div_rsp_t rsp
);
  logic [63:0]        num_r, num_nxt;
  logic [BYTES_W-1:0] rem_r, rem_nxt;
  logic [BYTES_W-1:0] div_r;
  logic [3:0]         cnt_r;
  logic               busy_r;
  logic               done_r;

  always_comb begin
    logic [BYTES_W:0] t;
    logic [BYTES_W-1:0] r;
    r = rem_r;
    for (int k = 0; k < 4; k++) begin
      t = {r, num_r[63-k]};
      if (t >= {1'b0, div_r}) t = t - {1'b0, div_r};
      r = t[BYTES_W-1:0];
    end
    rem_nxt = r;
    num_nxt = num_r << 4;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.dividend;
      rem_r <= '0;
      div_r <= req.divisor;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r[ADDR_W-1:0];
endmodule

// File: sv/sbf_store.sv
// ----------------------------------------------------------------------------
// Seeded Bloom filter bit store
// Byte-wide synchronous RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sbf_store import sbf_pkg::*; (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);
  logic [7:0] mem [MAX_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end
endmodule

// File: sv/seeded_bloom_filter.sv
// Sequence: insert and query run, for each hash in use, the hash step, the four-bit-per-cycle
// modulo unit, the store read and the check of the store byte; load seed goes straight to done.
// Clear sweeps the whole bit store, one byte a cycle.
// One item at a time; the next word is taken once the result is in the output register.
// Reset (rst_n low, synchronous) starts the same sweep; no input is taken then.
// ----------------------------------------------------------------------------
// Seeded Bloom filter
// Insert, query, clear and seed load over a byte-wide bit store.
// ----------------------------------------------------------------------------
`include "seeded_bloom_filter_defines.svh"
module seeded_bloom_filter import sbf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // key_hash[63:0], seed_index[67:64], seed_value[131:68], table_bytes[145:132],
  // count_limit[165:146], hash_count[170:166], zero fill
  input  logic [175:0] in_tdata,
  // op[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // present[0], element_count[20:1], needs_rebuild[21], zero fill
  output logic [23:0]  out_tdata
);
  sbf_state_t state_r, state_nxt;
  logic [63:0]        seed_r [MAX_HASHES];
  logic [63:0]        h_r, h_nxt;
  sbf_op_t            op_r;
  logic [SEED_W-1:0]  probe_r;
  logic [BYTES_W-1:0] bytes_r;
  logic [HCNT_W-1:0]  hashes_r;
  logic [COUNT_W-1:0] limit_r, count_r;
  logic [COUNT_W-1:0] count_nxt;
  logic [ADDR_W-1:0]  clr_addr_r, addr_r;
  logic               clr_item_r, all_r;
  logic               out_valid_r;
  logic [23:0]        out_data_r;
  logic [7:0]         rd_data;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [7:0]         wr_data;
  logic               in_acc, out_load, last_probe, probe_bit;
  sbf_div_req_t       dreq;
  sbf_div_rsp_t       drsp;
  logic [BYTES_W-1:0] tb;
  logic [HCNT_W-1:0]  hc;

  assign in_acc     = in_tvalid && in_tready;
  assign last_probe = ({1'b0, probe_r} == hashes_r - HCNT_W'(1));
  assign probe_bit  = rd_data[h_r[2:0]];
  assign h_nxt      = rotl(h_r) ^ seed_r[probe_r];
  assign count_nxt  = (op_r == OP_INSERT && count_r != COUNT_MAX) ?
                      count_r + COUNT_W'(1) : count_r;

  always_comb begin
    tb = in_tdata[145:132];
    hc = in_tdata[170:166];
    if (tb == '0) tb = BYTES_W'(1);
    if (tb > BYTES_W'(MAX_BYTES)) tb = BYTES_W'(MAX_BYTES);
    if (hc == '0) hc = HCNT_W'(1);
    if (hc > HCNT_W'(MAX_HASHES)) hc = HCNT_W'(MAX_HASHES);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_addr_r == ADDR_W'(MAX_BYTES - 1))
                  state_nxt = clr_item_r ? ST_DONE : ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          unique case (sbf_op_t'(in_tuser))
            OP_INSERT, OP_QUERY: state_nxt = ST_HASH;
            OP_CLEAR:            state_nxt = ST_CLEAR;
            OP_SEED:             state_nxt = ST_DONE;
            default:             state_nxt = ST_DONE;
          endcase
        end
      end
      ST_HASH: state_nxt = ST_DIV;
      ST_DIV:  if (drsp.done) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_CHK;
      ST_CHK:  state_nxt = last_probe ? ST_DONE : ST_HASH;
      ST_DONE: if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = (state_r == ST_IDLE);
    out_load      = (state_r == ST_DONE) && (!out_valid_r || out_tready);
    dreq.start    = (state_r == ST_HASH);
    dreq.dividend = {3'b000, h_nxt[63:3]};
    dreq.divisor  = bytes_r;
    wr_en         = 1'b0;
    wr_addr       = addr_r;
    wr_data       = rd_data | (8'd1 << h_r[2:0]);
    if (state_r == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = '0;
    end else if (state_r == ST_CHK && op_r == OP_INSERT) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_item_r  <= 1'b0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      bytes_r     <= BYTES_W'(1);
      hashes_r    <= HCNT_W'(1);
      limit_r     <= '0;
      count_r     <= '0;
      for (int i = 0; i < MAX_HASHES; i++) seed_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_addr_r <= clr_addr_r + ADDR_W'(1);
      if (out_load) begin
        out_valid_r <= 1'b1;
        count_r     <= count_nxt;
      end else if (out_tvalid && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc) begin
        if (sbf_op_t'(in_tuser) == OP_CLEAR) begin
          clr_item_r <= 1'b1;
          clr_addr_r <= '0;
          bytes_r    <= tb;
          hashes_r   <= hc;
          limit_r    <= in_tdata[165:146];
          count_r    <= '0;
        end
        if (sbf_op_t'(in_tuser) == OP_SEED &&
            {1'b0, in_tdata[67:64]} < (SEED_W + 1)'(MAX_HASHES))
          seed_r[in_tdata[64 +: SEED_W]] <= in_tdata[131:68];
      end
    end
  end

  // Probe datapath; the store byte read in ST_RD is checked and, for an insert, updated in ST_CHK.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= sbf_op_t'(in_tuser);
      h_r     <= in_tdata[63:0];
      probe_r <= '0;
      all_r   <= 1'b1;
    end
    if (state_r == ST_HASH) h_r <= h_nxt;
    if (drsp.done) addr_r <= drsp.rem;
    if (state_r == ST_CHK) begin
      all_r   <= all_r & probe_bit;
      probe_r <= probe_r + SEED_W'(1);
    end
    // The result word is held here so that a new item cannot disturb it while it waits.
    if (out_load)
      out_data_r <= {2'b00, (count_nxt > limit_r), count_nxt, (op_r == OP_QUERY) && all_r};
  end

  sbf_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  sbf_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `SBF_ASSERT(a_chk_after_rd, (state_r == ST_CHK) |-> ($past(state_r) == ST_RD), "check without read")
  `SBF_ASSERT(a_div_done_wait, drsp.done |-> (state_r == ST_DIV), "modulo done outside wait")
  `SBF_ASSERT(a_clear_sweep, (in_acc && in_tuser == OP_CLEAR) |=> (state_r == ST_CLEAR), "clear not swept")
  `SBF_ASSERT_ALWAYS(a_reset_sweep, !rst_n |=> (state_r == ST_CLEAR && !out_valid_r), "reset state")
endmodule
